[hdl/tpc_pkg.sv]
// Package for the triangle plane clipper: constants, types and crossing tables.
`default_nettype none
package tpc_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 16;
   localparam int unsigned T_BITS            = 31;
   localparam int unsigned SW                = 68;
   localparam int unsigned PW                = 66;

   localparam logic [1:0] REG_NORMAL_X     = 2'd0;
   localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
   localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
   localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

   localparam logic [2:0] CODE_X1 = 3'd3;
   localparam logic [2:0] CODE_X2 = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_CLASS,
      ST_DLOAD,
      ST_DDEN,
      ST_DIV,
      ST_LA,
      ST_LMUL,
      ST_LADD,
      ST_EMIT
   } tpc_state_type;

   typedef struct packed {
      logic [1:0] ia;
      logic [1:0] ob;
   } tpc_pair_type;

   function automatic tpc_pair_type cross_pair(input logic [2:0] mask, input logic j);
      tpc_pair_type r;
      r = '{ia: 2'd0, ob: 2'd1};
      case (mask)
         3'b001: r = j ? '{ia: 2'd0, ob: 2'd2} : '{ia: 2'd0, ob: 2'd1};
         3'b010: r = j ? '{ia: 2'd1, ob: 2'd2} : '{ia: 2'd1, ob: 2'd0};
         3'b100: r = j ? '{ia: 2'd2, ob: 2'd1} : '{ia: 2'd2, ob: 2'd0};
         3'b011: r = j ? '{ia: 2'd1, ob: 2'd2} : '{ia: 2'd0, ob: 2'd2};
         3'b101: r = j ? '{ia: 2'd2, ob: 2'd1} : '{ia: 2'd0, ob: 2'd1};
         3'b110: r = j ? '{ia: 2'd2, ob: 2'd0} : '{ia: 2'd1, ob: 2'd0};
         default: r = '{ia: 2'd0, ob: 2'd1};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/triangle_plane_clipper_core.sv]
// Top level of the triangle plane clipper with its sequencer and shared datapath.
`default_nettype none
// Vertices arrive one per transaction; the first two of a triangle are held. The third
// starts the work on a single shared multiplier and a one-bit-per-cycle divider: nine
// multiply-accumulate pairs for the plane distances, then per edge crossing a division and
// the four interpolations before the first vertex of a clipped triangle leaves. Result
// vertices then leave one per cycle while the consumer is ready. No new vertex is taken while
// a triangle is being processed or emitted.
module triangle_plane_clipper_core #(
   parameter int unsigned FRAC_BITS = tpc_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_vert_x,
   input  wire logic signed [31:0] req_vert_y,
   input  wire logic signed [31:0] req_vert_z,
   input  wire logic signed [31:0] req_vert_w,
   input  wire logic        [31:0] req_tri_color,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic signed [31:0]      rsp_out_w,
   output logic        [31:0]      rsp_out_color,
   output logic                    rsp_end_of_triangle,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import tpc_pkg::*;

   tpc_state_type state_ff, state_in;

   logic signed [31:0] nrm_ff [4];
   logic signed [31:0] vtx_ff [3][4];
   logic signed [31:0] vtx_in [3][4];
   logic signed [31:0] xs_ff [2][4];
   logic signed [31:0] xs_in [2][4];
   logic signed [SW-1:0] s_ff [3];
   logic signed [SW-1:0] s_in [3];
   logic [31:0]  color_ff, color_in;
   logic [1:0]   slot_ff, slot_in;
   logic [1:0]   vi_ff, vi_in;
   logic [1:0]   ci_ff, ci_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] den_ff, den_in;
   logic [T_BITS-1:0] q_ff, q_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic signed [31:0] a_ff, a_in;
   logic         j_ff, j_in;
   logic [2:0]   mask_ff, mask_in;
   logic [2:0]   e_ff, e_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [31:0] rsp_z_ff, rsp_z_in, rsp_w_ff, rsp_w_in;
   logic [31:0]        rsp_color_ff, rsp_color_in;
   logic               rsp_eot_ff, rsp_eot_in, rsp_last_ff, rsp_last_in;

   tpc_pair_type pair, pair0, pair1;
   logic [1:0]   rd_idx;
   logic signed [31:0] rd_row [4];
   logic signed [32:0] mul_a, mul_b;
   logic signed [SW-1:0] acc_init, acc_sum;
   logic [SW-1:0] rem_sh;
   logic signed [PW-1:0] step;
   logic [2:0]   code;
   logic [1:0]   ni;
   logic         six, emit_go, emit_last, req_fire;
   logic [2:0]   mask_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign pair      = cross_pair(mask_ff, j_ff);
   assign pair0     = cross_pair(mask_ff, 1'b0);
   assign pair1     = cross_pair(mask_ff, 1'b1);
   assign six       = ($countones(mask_ff) == 2);
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = six ? (e_ff == 3'd5) : (e_ff == 3'd2);
   assign mask_now  = {~s_ff[2][SW-1], ~s_ff[1][SW-1], ~s_ff[0][SW-1]};
   assign ni        = 2'($countones(mask_now));
   assign acc_init  = {{(SW-32){nrm_ff[REG_PLANE_OFFSET][31]}}, nrm_ff[REG_PLANE_OFFSET]}
                      <<< FRAC_BITS;
   assign acc_sum   = acc_ff + {{(SW-PW){prod_ff[PW-1]}}, prod_ff};
   assign rem_sh    = {rem_ff[SW-2:0], 1'b0};
   assign step      = prod_ff >>> T_BITS;

   always_comb begin
      code = {1'b0, e_ff[1:0]};
      if (mask_ff != 3'b111) begin
         if (!six) begin
            case (e_ff)
               3'd0:    code = {1'b0, pair0.ia};
               3'd1:    code = CODE_X1;
               default: code = CODE_X2;
            endcase
         end else begin
            case (e_ff)
               3'd0:    code = {1'b0, pair0.ia};
               3'd1:    code = {1'b0, pair1.ia};
               3'd2:    code = CODE_X1;
               3'd3:    code = {1'b0, pair1.ia};
               3'd4:    code = CODE_X1;
               default: code = CODE_X2;
            endcase
         end
      end
   end

   always_comb begin
      case (state_ff)
         ST_MUL:  rd_idx = vi_ff;
         ST_LA:   rd_idx = pair.ia;
         ST_LMUL: rd_idx = pair.ob;
         default: rd_idx = code[1:0];
      endcase
      case (rd_idx)
         2'd0:    rd_row = vtx_ff[0];
         2'd1:    rd_row = vtx_ff[1];
         default: rd_row = vtx_ff[2];
      endcase
      if (state_ff == ST_LMUL) begin
         mul_a = {rd_row[ci_ff][31], rd_row[ci_ff]} - {a_ff[31], a_ff};
         mul_b = {2'b00, q_ff};
      end else begin
         mul_a = {nrm_ff[ci_ff][31], nrm_ff[ci_ff]};
         mul_b = {rd_row[ci_ff][31], rd_row[ci_ff]};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && slot_ff == 2'd2) state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = (ci_ff == 2'd2 && vi_ff == 2'd2) ? ST_CLASS : ST_MUL;
         ST_CLASS: begin
            if (ni == 2'd3)      state_in = ST_EMIT;
            else if (ni == 2'd0) state_in = ST_IDLE;
            else                 state_in = ST_DLOAD;
         end
         ST_DLOAD: state_in = ST_DDEN;
         ST_DDEN:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 5'(T_BITS - 1)) state_in = ST_LA;
         ST_LA:    state_in = ST_LMUL;
         ST_LMUL:  state_in = ST_LADD;
         ST_LADD:  begin
            if (ci_ff == 2'd3) state_in = j_ff ? ST_EMIT : ST_DLOAD;
            else               state_in = ST_LA;
         end
         ST_EMIT:  if (emit_go && emit_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      vtx_in   = vtx_ff;
      xs_in    = xs_ff;
      s_in     = s_ff;
      color_in = color_ff;
      slot_in  = slot_ff;
      vi_in    = vi_ff;
      ci_in    = ci_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      j_in     = j_ff;
      mask_in  = mask_ff;
      e_in     = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_color_in = rsp_color_ff;
      rsp_eot_in   = rsp_eot_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               vtx_in[slot_ff] = '{req_vert_x, req_vert_y, req_vert_z, req_vert_w};
               if (slot_ff == 2'd2) begin
                  slot_in  = 2'd0;
                  color_in = req_tri_color;
                  vi_in    = 2'd0;
                  ci_in    = 2'd0;
                  acc_in   = -acc_init;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end
         end
         ST_MUL: prod_in = PW'(mul_a * mul_b);
         ST_ACC: begin
            if (ci_ff == 2'd2) begin
               s_in[vi_ff] = acc_sum;
               vi_in       = vi_ff + 2'd1;
               ci_in       = 2'd0;
               acc_in      = -acc_init;
            end else begin
               acc_in = acc_sum;
               ci_in  = ci_ff + 2'd1;
            end
         end
         ST_CLASS: begin
            mask_in = mask_now;
            j_in    = 1'b0;
            e_in    = 3'd0;
         end
         ST_DLOAD: rem_in = s_ff[pair.ia];
         ST_DDEN: begin
            den_in = rem_ff - s_ff[pair.ob];
            cnt_in = 5'd0;
            q_in   = '0;
         end
         ST_DIV: begin
            if (rem_sh >= den_ff) begin
               rem_in = rem_sh - den_ff;
               q_in   = {q_ff[T_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[T_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            ci_in  = 2'd0;
         end
         ST_LA:   a_in = rd_row[ci_ff];
         ST_LMUL: prod_in = PW'(mul_a * mul_b);
         ST_LADD: begin
            xs_in[j_ff][ci_ff] = a_ff + step[31:0];
            ci_in = ci_ff + 2'd1;
            if (ci_ff == 2'd3) begin
               j_in = 1'b1;
               e_in = 3'd0;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               if (code == CODE_X1) begin
                  rsp_x_in = xs_ff[0][0]; rsp_y_in = xs_ff[0][1];
                  rsp_z_in = xs_ff[0][2]; rsp_w_in = xs_ff[0][3];
               end else if (code == CODE_X2) begin
                  rsp_x_in = xs_ff[1][0]; rsp_y_in = xs_ff[1][1];
                  rsp_z_in = xs_ff[1][2]; rsp_w_in = xs_ff[1][3];
               end else begin
                  rsp_x_in = rd_row[0]; rsp_y_in = rd_row[1];
                  rsp_z_in = rd_row[2]; rsp_w_in = rd_row[3];
               end
               rsp_color_in = color_ff;
               rsp_eot_in   = (e_ff == 3'd2) || (e_ff == 3'd5);
               rsp_last_in  = emit_last;
               e_in         = e_ff + 3'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         nrm_ff[REG_NORMAL_X]     <= 32'sd0;
         nrm_ff[REG_NORMAL_Y]     <= 32'sd0;
         nrm_ff[REG_NORMAL_Z]     <= 32'sd65536;
         nrm_ff[REG_PLANE_OFFSET] <= 32'sd0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) nrm_ff[csr_index] <= csr_data;
      end
      vtx_ff   <= vtx_in;
      xs_ff    <= xs_in;
      s_ff     <= s_in;
      color_ff <= color_in;
      vi_ff    <= vi_in;
      ci_ff    <= ci_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      j_ff     <= j_in;
      mask_ff  <= mask_in;
      e_ff     <= e_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_w_ff     <= rsp_w_in;
      rsp_color_ff <= rsp_color_in;
      rsp_eot_ff   <= rsp_eot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = rsp_x_ff;
   assign rsp_out_y           = rsp_y_ff;
   assign rsp_out_z           = rsp_z_ff;
   assign rsp_out_w           = rsp_w_ff;
   assign rsp_out_color       = rsp_color_ff;
   assign rsp_end_of_triangle = rsp_eot_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire
